// ===== src/thls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thls_pkg
// Shared types, codes and reset values for the thermal head line sequencer.
// ----------------------------------------------------------------------------
package thls_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned WIDX_W   = 5;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned TMR_W    = 24;
  localparam int unsigned STEPS_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Default line length in words
  localparam int unsigned LINE_WORDS_DEF = 24;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRINTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOLD_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURN_NORMAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURN_BOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_STEPS = 3'd6;

  // Register reset values
  localparam logic [15:0]         RST_BURN_NORMAL = 16'd2500;
  localparam logic [15:0]         RST_BURN_BOLD   = 16'd3500;
  localparam logic [15:0]         RST_LATCH       = 16'd100;
  localparam logic [TMR_W-1:0]    RST_COOLDOWN    = 24'd5000000;
  localparam logic [TEMP_W-1:0]   RST_HOT_THRESH  = 12'd3000;
  localparam logic [STEPS_W-1:0]  RST_MOTOR_STEPS = 8'd8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COOL,
    PH_SHIFT,
    PH_LATCH_LO,
    PH_LATCH_HI,
    PH_BURN_A,
    PH_BURN_B
  } phase_t;

  typedef enum logic [2:0] {
    TMR_HOLD,
    TMR_DEC,
    TMR_COOL,
    TMR_LATCH,
    TMR_BURN,
    TMR_CLEAR
  } tmr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    out_load;
    logic    buf_wr;
    tmr_op_t tmr_op;
    cnt_op_t cnt_op;
    logic    shift;
    logic    latch_low;
    logic    strobe_a;
    logic    strobe_b;
    logic    done;
    logic    refused;
    logic    motor;
    logic    busy;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hot;
    logic idx_ok;
    logic tmr_end;
    logic cnt_last;
    logic latch_zero;
    logic burn_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/thls_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thls_ctrl
// Phase sequencer: decodes each transaction and steers the datapath.
// ----------------------------------------------------------------------------
module thls_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_fire,
  input  wire logic [thls_pkg::CMD_W-1:0]   cmd,
  input  wire logic                         paper_present,
  input  wire thls_pkg::dp_stat_t           stat,
  output thls_pkg::ctrl_cmd_t               ccmd
);

  thls_pkg::phase_t phase, phase_next;
  logic             motor_on, motor_on_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= thls_pkg::PH_IDLE;
      motor_on <= 1'b1;
    end else begin
      phase    <= phase_next;
      motor_on <= motor_on_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    motor_on_next = motor_on;
    ccmd          = '0;
    ccmd.tmr_op   = thls_pkg::TMR_HOLD;
    ccmd.cnt_op   = thls_pkg::CNT_HOLD;
    ccmd.out_load = in_fire;

    if (in_fire) begin
      priority if (cmd == thls_pkg::CMD_LOAD) begin
        ccmd.buf_wr = stat.idx_ok;
      end else if (cmd == thls_pkg::CMD_START) begin
        if (phase == thls_pkg::PH_IDLE) begin
          priority if (!paper_present) begin
            ccmd.refused = 1'b1;
          end else if (stat.hot) begin
            phase_next    = thls_pkg::PH_COOL;
            motor_on_next = 1'b0;
            ccmd.tmr_op   = thls_pkg::TMR_COOL;
          end else begin
            phase_next  = thls_pkg::PH_SHIFT;
            ccmd.cnt_op = thls_pkg::CNT_CLEAR;
          end
        end
      end else if (cmd == thls_pkg::CMD_TICK) begin
        unique case (phase)
          thls_pkg::PH_COOL: begin
            ccmd.tmr_op = thls_pkg::TMR_DEC;
            if (stat.tmr_end) begin
              if (stat.hot) begin
                motor_on_next = 1'b0;
                ccmd.tmr_op   = thls_pkg::TMR_COOL;
              end else begin
                phase_next  = thls_pkg::PH_SHIFT;
                ccmd.cnt_op = thls_pkg::CNT_CLEAR;
              end
            end
          end
          thls_pkg::PH_SHIFT: begin
            ccmd.shift  = 1'b1;
            ccmd.cnt_op = thls_pkg::CNT_INC;
            if (stat.cnt_last) begin
              ccmd.cnt_op = thls_pkg::CNT_CLEAR;
              priority if (!stat.latch_zero) begin
                phase_next  = thls_pkg::PH_LATCH_LO;
                ccmd.tmr_op = thls_pkg::TMR_LATCH;
              end else if (!stat.burn_zero) begin
                phase_next  = thls_pkg::PH_BURN_A;
                ccmd.tmr_op = thls_pkg::TMR_BURN;
              end else begin
                ccmd.done = 1'b1;
              end
            end
          end
          thls_pkg::PH_LATCH_LO: begin
            ccmd.latch_low = 1'b1;
            ccmd.tmr_op    = thls_pkg::TMR_DEC;
            if (stat.tmr_end) begin
              priority if (!stat.latch_zero) begin
                phase_next  = thls_pkg::PH_LATCH_HI;
                ccmd.tmr_op = thls_pkg::TMR_LATCH;
              end else if (!stat.burn_zero) begin
                phase_next  = thls_pkg::PH_BURN_A;
                ccmd.tmr_op = thls_pkg::TMR_BURN;
              end else begin
                ccmd.done = 1'b1;
              end
            end
          end
          thls_pkg::PH_LATCH_HI: begin
            ccmd.tmr_op = thls_pkg::TMR_DEC;
            if (stat.tmr_end) begin
              if (!stat.burn_zero) begin
                phase_next  = thls_pkg::PH_BURN_A;
                ccmd.tmr_op = thls_pkg::TMR_BURN;
              end else begin
                ccmd.done = 1'b1;
              end
            end
          end
          thls_pkg::PH_BURN_A: begin
            ccmd.strobe_a = 1'b1;
            ccmd.tmr_op   = thls_pkg::TMR_DEC;
            if (stat.tmr_end) begin
              if (!stat.burn_zero) begin
                phase_next  = thls_pkg::PH_BURN_B;
                ccmd.tmr_op = thls_pkg::TMR_BURN;
              end else begin
                ccmd.done = 1'b1;
              end
            end
          end
          thls_pkg::PH_BURN_B: begin
            ccmd.strobe_b = 1'b1;
            ccmd.tmr_op   = thls_pkg::TMR_DEC;
            if (stat.tmr_end) begin
              ccmd.done = 1'b1;
            end
          end
          default: begin
            // idle: ticks change nothing
          end
        endcase
      end else begin
        // unused command code: ignored
      end
    end

    if (ccmd.done) begin
      phase_next    = thls_pkg::PH_IDLE;
      motor_on_next = 1'b1;
      ccmd.tmr_op   = thls_pkg::TMR_CLEAR;
      ccmd.cnt_op   = thls_pkg::CNT_CLEAR;
    end

    ccmd.motor = motor_on_next;
    ccmd.busy  = (phase_next != thls_pkg::PH_IDLE);
  end

endmodule
`default_nettype wire

// ===== src/thls_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thls_datapath
// Config registers, line buffer, phase timer, word counter, result register.
// ----------------------------------------------------------------------------
module thls_datapath #(
  parameter int unsigned LINE_WORDS = thls_pkg::LINE_WORDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire thls_pkg::ctrl_cmd_t               ccmd,
  output thls_pkg::dp_stat_t                     stat,
  input  wire logic                              cfg_wr,
  input  wire logic [thls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [thls_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [thls_pkg::WIDX_W-1:0]       word_index,
  input  wire logic [thls_pkg::WORD_W-1:0]       word_data,
  input  wire logic [thls_pkg::TEMP_W-1:0]       temp_sample,
  input  wire logic                              out_ready,
  output logic                                   in_ready,
  output logic                                   out_valid,
  output logic [thls_pkg::WORD_W-1:0]            shift_word,
  output logic                                   shift_valid,
  output logic                                   latch_level,
  output logic                                   strobe_a,
  output logic                                   strobe_b,
  output logic                                   motor_enable,
  output logic [thls_pkg::STEPS_W-1:0]           step_request,
  output logic                                   step_valid,
  output logic [thls_pkg::STATUS_W-1:0]          status,
  output logic                                   busy_res
);

  localparam int unsigned IDX_W = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int unsigned EXT_W = 8;  // covers both word_index and IDX_W
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_WORDS - 1);

  // Configuration registers
  logic                          bold_mode;
  logic [15:0]                   burn_normal_us;
  logic [15:0]                   burn_bold_us;
  logic [15:0]                   latch_us;
  logic [thls_pkg::TMR_W-1:0]    cooldown_us;
  logic [thls_pkg::TEMP_W-1:0]   hot_adc_threshold;
  logic [thls_pkg::STEPS_W-1:0]  motor_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      bold_mode         <= 1'b0;
      burn_normal_us    <= thls_pkg::RST_BURN_NORMAL;
      burn_bold_us      <= thls_pkg::RST_BURN_BOLD;
      latch_us          <= thls_pkg::RST_LATCH;
      cooldown_us       <= thls_pkg::RST_COOLDOWN;
      hot_adc_threshold <= thls_pkg::RST_HOT_THRESH;
      motor_steps       <= thls_pkg::RST_MOTOR_STEPS;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        thls_pkg::REG_BOLD_MODE:   bold_mode         <= cfg_data[0];
        thls_pkg::REG_BURN_NORMAL: burn_normal_us    <= cfg_data[15:0];
        thls_pkg::REG_BURN_BOLD:   burn_bold_us      <= cfg_data[15:0];
        thls_pkg::REG_LATCH:       latch_us          <= cfg_data[15:0];
        thls_pkg::REG_COOLDOWN:    cooldown_us       <= cfg_data;
        thls_pkg::REG_HOT_THRESH:  hot_adc_threshold <= cfg_data[thls_pkg::TEMP_W-1:0];
        thls_pkg::REG_MOTOR_STEPS: motor_steps       <= cfg_data[thls_pkg::STEPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [15:0] burn_sel;
  assign burn_sel = bold_mode ? burn_bold_us : burn_normal_us;

  // Phase timer
  logic [thls_pkg::TMR_W-1:0] timer, timer_next, timer_dec;

  assign timer_dec = (timer != '0) ? timer - 1'b1 : '0;

  always_comb begin
    unique case (ccmd.tmr_op)
      thls_pkg::TMR_HOLD:  timer_next = timer;
      thls_pkg::TMR_DEC:   timer_next = timer_dec;
      thls_pkg::TMR_COOL:  timer_next = cooldown_us;
      thls_pkg::TMR_LATCH: timer_next = {{(thls_pkg::TMR_W-16){1'b0}}, latch_us};
      thls_pkg::TMR_BURN:  timer_next = {{(thls_pkg::TMR_W-16){1'b0}}, burn_sel};
      thls_pkg::TMR_CLEAR: timer_next = '0;
      default:             timer_next = timer;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else begin
      timer <= timer_next;
    end
  end

  // Word counter
  logic [IDX_W-1:0] count, count_next;

  always_comb begin
    unique case (ccmd.cnt_op)
      thls_pkg::CNT_HOLD:  count_next = count;
      thls_pkg::CNT_CLEAR: count_next = '0;
      thls_pkg::CNT_INC:   count_next = count + 1'b1;
      default:             count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Line buffer; rd_word always holds the entry at the current count
  logic [thls_pkg::WORD_W-1:0] line_buffer [LINE_WORDS];
  logic [thls_pkg::WORD_W-1:0] rd_word;
  logic [EXT_W-1:0]            widx_ext;
  logic [IDX_W-1:0]            waddr;

  assign widx_ext = {{(EXT_W-thls_pkg::WIDX_W){1'b0}}, word_index};
  assign waddr    = widx_ext[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ccmd.buf_wr) begin
      line_buffer[waddr] <= word_data;
    end
    if (ccmd.buf_wr && (waddr == count_next)) begin
      rd_word <= word_data;
    end else begin
      rd_word <= line_buffer[count_next];
    end
  end

  // Status to the controller
  assign stat.hot        = (temp_sample > hot_adc_threshold);
  assign stat.idx_ok     = (int'(word_index) < LINE_WORDS);
  assign stat.tmr_end    = (timer[thls_pkg::TMR_W-1:1] == '0);
  assign stat.cnt_last   = (count == LAST_IDX);
  assign stat.latch_zero = (latch_us == '0);
  assign stat.burn_zero  = (burn_sel == '0);

  // Result register
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ccmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ccmd.out_load) begin
      shift_word   <= ccmd.shift ? rd_word : '0;
      shift_valid  <= ccmd.shift;
      latch_level  <= !ccmd.latch_low;
      strobe_a     <= ccmd.strobe_a;
      strobe_b     <= ccmd.strobe_b;
      motor_enable <= ccmd.motor;
      step_request <= ccmd.done ? motor_steps : '0;
      step_valid   <= ccmd.done;
      busy_res     <= ccmd.busy;
      priority if (ccmd.done) begin
        status <= thls_pkg::ST_PRINTED;
      end else if (ccmd.refused) begin
        status <= thls_pkg::ST_REFUSED;
      end else begin
        status <= thls_pkg::ST_NONE;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/thermal_head_line_sequencer.sv =====
`default_nettype none
// The result of a transaction is registered in the output register in the cycle after it is taken.
// Throughput: one transaction per clock while out_ready lets the result register
//   drain; the register with its ready bypass sets this, every command finishes in the cycle it is taken.
// Reset (rst, synchronous): phase idle, timer and word counter zero, motor on,
//   registers to defaults; line buffer contents are not cleared.
// ----------------------------------------------------------------------------
// thermal_head_line_sequencer
// Prints one dot line on a thermal head: buffer load, overheat cooldown,
// word shift-out, latch pulse, two strobe groups and a feed-step request.
// ----------------------------------------------------------------------------
module thermal_head_line_sequencer #(
  parameter int unsigned LINE_WORDS = thls_pkg::LINE_WORDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // item input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [thls_pkg::CMD_W-1:0]        cmd,
  input  wire logic [thls_pkg::WIDX_W-1:0]       word_index,
  input  wire logic [thls_pkg::WORD_W-1:0]       word_data,
  input  wire logic                              paper_present,
  input  wire logic [thls_pkg::TEMP_W-1:0]       temp_sample,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [thls_pkg::WORD_W-1:0]            shift_word,
  output logic                                   shift_valid,
  output logic                                   latch_level,
  output logic                                   strobe_a,
  output logic                                   strobe_b,
  output logic                                   motor_enable,
  output logic [thls_pkg::STEPS_W-1:0]           step_request,
  output logic                                   step_valid,
  output logic [thls_pkg::STATUS_W-1:0]          status,
  output logic                                   busy_res,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [thls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [thls_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Register writes always complete; software must only write while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  logic                in_fire;
  logic                cfg_wr;
  thls_pkg::ctrl_cmd_t ccmd;
  thls_pkg::dp_stat_t  stat;

  // A transaction is taken whenever the result register is free or being
  // drained this cycle; a result that waits on out_ready blocks the next command.
  assign in_fire = in_valid && in_ready;
  assign cfg_wr  = cfg_valid && cfg_ready;

  // Controller: holds the print phase and the motor enable; decides per
  // transaction what the timer, counter and buffer do and what is reported.
  thls_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .cmd           (cmd),
    .paper_present (paper_present),
    .stat          (stat),
    .ccmd          (ccmd)
  );

  // Datapath: configuration, line buffer with prefetched read word, 24-bit
  // microsecond timer, word counter and the result register.
  thls_datapath #(
    .LINE_WORDS (LINE_WORDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ccmd         (ccmd),
    .stat         (stat),
    .cfg_wr       (cfg_wr),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .word_index   (word_index),
    .word_data    (word_data),
    .temp_sample  (temp_sample),
    .out_ready    (out_ready),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .shift_word   (shift_word),
    .shift_valid  (shift_valid),
    .latch_level  (latch_level),
    .strobe_a     (strobe_a),
    .strobe_b     (strobe_b),
    .motor_enable (motor_enable),
    .step_request (step_request),
    .step_valid   (step_valid),
    .status       (status),
    .busy_res     (busy_res)
  );

  // Checks

  // The two heater groups never burn together.
  a_strobe_excl : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(strobe_a && strobe_b))
    else $error("strobe groups A and B active together");

  // A finished line reports printed status and leaves the block idle.
  a_done_status : assert property (@(posedge clk) disable iff (rst)
    (out_valid && step_valid) |-> (status == thls_pkg::ST_PRINTED && !busy_res))
    else $error("line finish without printed status or still busy");

  // Latch stays high while words are being shifted.
  a_shift_latch : assert property (@(posedge clk) disable iff (rst)
    (out_valid && shift_valid) |-> (latch_level && !strobe_a && !strobe_b))
    else $error("latch or strobe active during shift-out");

  // The motor is only off during a print sequence (from cooldown until the line finishes).
  a_motor_busy : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !motor_enable) |-> busy_res)
    else $error("motor off while idle");

endmodule
`default_nettype wire
